>>> hdl/i2d_pkg.sv
// ----------------------------------------------------------------------------
// i2d_pkg - shared types and constants for the 128-bit integer to decimal text block
// Holds field widths, character codes, the BCD digit array type, the control
// state type and the start record that passes from the top level to the emitter.
// ----------------------------------------------------------------------------
package i2d_pkg;

	localparam int MagW      = 128;  // magnitude width
	localparam int HalfW     = 64;   // width of each input half
	localparam int NumDigits = 39;   // decimal digits of 2^127
	localparam int DigitIdxW = 6;    // enough to index and count 39 digits
	localparam int BitCntW   = 7;    // counts the 128 conversion steps
	localparam int CharW     = 6;    // output character code width

	localparam logic [CharW-1:0] CodeMinus = 6'd45;
	localparam logic [CharW-1:0] CodeZero  = 6'd48;
	localparam logic [3:0]       DabbleMin = 4'd5;
	localparam logic [3:0]       DabbleAdd = 4'd3;

	typedef logic [NumDigits-1:0][3:0] digits_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_START,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic                 start;
		logic                 negative;
		logic [DigitIdxW-1:0] top_idx;
	} emit_start_t;

endpackage

>>> hdl/i2d_dabble.sv
// ----------------------------------------------------------------------------
// i2d_dabble - bit-serial binary to BCD converter
// Shifts the magnitude in one bit per cycle while shift_en is high, most significant first, into a
// 39-digit BCD register using the add-three rule, and keeps a running count of
// significant digits so that no leading-zero search is needed afterwards.
// ----------------------------------------------------------------------------
module i2d_dabble (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic [i2d_pkg::MagW-1:0]      magnitude,
	input  logic                          shift_en,
	output logic                          done,
	output i2d_pkg::digits_t              digits,
	output logic [i2d_pkg::DigitIdxW-1:0] num_digits
);

	localparam logic [i2d_pkg::BitCntW-1:0] LastStep = i2d_pkg::BitCntW'(i2d_pkg::MagW - 1);
	localparam logic [i2d_pkg::DigitIdxW-1:0] MaxDigits =
		i2d_pkg::DigitIdxW'(i2d_pkg::NumDigits);

	logic [i2d_pkg::MagW-1:0]      bin_q;
	i2d_pkg::digits_t              bcd_q;
	logic [i2d_pkg::DigitIdxW-1:0] ndig_q;
	logic [i2d_pkg::BitCntW-1:0]   step_q;

	i2d_pkg::digits_t adj;
	i2d_pkg::digits_t bcd_next;
	logic             grow;

	always_comb begin
		for (int i = 0; i < i2d_pkg::NumDigits; i++) begin
			adj[i] = (bcd_q[i] >= i2d_pkg::DabbleMin) ?
				bcd_q[i] + i2d_pkg::DabbleAdd : bcd_q[i];
		end
		// The whole BCD register moves up one bit and takes the next binary bit.
		bcd_next = {adj[i2d_pkg::NumDigits-1][2:0], adj[i2d_pkg::NumDigits-2:0],
			bin_q[i2d_pkg::MagW-1]};
	end

	// Doubling a number adds at most one decimal digit, so only the digit just
	// above the current count has to be checked after each step.
	assign grow = (ndig_q != MaxDigits) &&
		(bcd_next[ndig_q[i2d_pkg::DigitIdxW-1:0]] != 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ndig_q <= '0;
			step_q <= '0;
		end else if (load) begin
			ndig_q <= i2d_pkg::DigitIdxW'(1);
			step_q <= '0;
		end else if (shift_en) begin
			step_q <= step_q + 1'b1;
			if (grow) begin
				ndig_q <= ndig_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bin_q <= magnitude;
			bcd_q <= '0;
		end else if (shift_en) begin
			bin_q <= {bin_q[i2d_pkg::MagW-2:0], 1'b0};
			bcd_q <= bcd_next;
		end
	end

	assign done       = shift_en && (step_q == LastStep);
	assign digits     = bcd_q;
	assign num_digits = ndig_q;

endmodule

>>> hdl/i2d_emit.sv
// ----------------------------------------------------------------------------
// i2d_emit - character emitter with output register
// Sends an optional minus sign and then the BCD digits from the most
// significant one down, one character per transfer, flagging the last.
// ----------------------------------------------------------------------------
module i2d_emit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  i2d_pkg::emit_start_t            start,
	input  i2d_pkg::digits_t                digits,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [7:0]                      m_tdata,   // [5:0] char_code, [7:6] zero
	output logic                            m_tlast,   // last_char
	output logic                            done
);

	logic                          active_q;
	logic                          sign_q;
	logic [i2d_pkg::DigitIdxW-1:0] idx_q;
	logic                          tvalid_q;
	logic [i2d_pkg::CharW-1:0]     code_q;
	logic                          last_q;

	logic                      load;
	logic [i2d_pkg::CharW-1:0] next_code;
	logic                      next_last;

	assign load = active_q && (!tvalid_q || m_tready);

	always_comb begin
		if (sign_q) begin
			next_code = i2d_pkg::CodeMinus;
			next_last = 1'b0;
		end else begin
			next_code = i2d_pkg::CodeZero + {2'b00, digits[idx_q]};
			next_last = (idx_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			sign_q   <= 1'b0;
			idx_q    <= '0;
			tvalid_q <= 1'b0;
		end else begin
			if (load) begin
				tvalid_q <= 1'b1;
			end else if (m_tready) begin
				tvalid_q <= 1'b0;
			end

			if (start.start) begin
				active_q <= 1'b1;
				sign_q   <= start.negative;
				idx_q    <= start.top_idx;
			end else if (load) begin
				if (sign_q) begin
					sign_q <= 1'b0;
				end else if (idx_q == '0) begin
					active_q <= 1'b0;
				end else begin
					idx_q <= idx_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_q <= next_code;
			last_q <= next_last;
		end
	end

	assign done     = load && next_last;
	assign m_tvalid = tvalid_q;
	assign m_tdata  = {2'b00, code_q};
	assign m_tlast  = last_q;

endmodule

>>> hdl/int128_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// int128_to_decimal_ascii - signed 128-bit integer to decimal ASCII text
// Channel  Dir  Payload                                        Marker
// s_axis   in   tdata[63:0] value_high, [127:64] value_low     -
// m_axis   out  tdata[5:0] char_code                           tlast = last_char
//
// Each item passes through these steps in order: the input takes the item,
// the bit-serial BCD shifter converts all 128 magnitude bits, the emitter is
// started, and it sends one character per cycle while the output is not stalled.
// The input is ready again once the last character is in the output register.
// Reset clears all control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module int128_to_decimal_ascii (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // [63:0] value_high, [127:64] value_low
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [7:0]   m_tdata,   // [5:0] char_code, [7:6] zero
	output logic         m_tlast    // last_char
);

	i2d_pkg::state_t state_q;
	i2d_pkg::state_t state_next;

	logic                          neg_q;
	logic                          accept;
	logic [i2d_pkg::HalfW-1:0]     value_high;
	logic [i2d_pkg::HalfW-1:0]     value_low;
	logic [i2d_pkg::MagW-1:0]      magnitude;
	logic                          shift_en;
	logic                          conv_done;
	logic                          emit_done;
	i2d_pkg::digits_t              digits;
	logic [i2d_pkg::DigitIdxW-1:0] num_digits;
	i2d_pkg::emit_start_t          emit_start;

	assign value_high = s_tdata[i2d_pkg::HalfW-1:0];
	assign value_low  = s_tdata[i2d_pkg::MagW-1:i2d_pkg::HalfW];
	assign accept     = s_tvalid && s_tready;

	always_comb begin
		if (value_high[i2d_pkg::HalfW-1]) begin
			magnitude = ~{value_high, value_low} + 1'b1;
		end else begin
			magnitude = {value_high, value_low};
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			i2d_pkg::ST_IDLE: begin
				if (accept) begin
					state_next = i2d_pkg::ST_CONV;
				end
			end
			i2d_pkg::ST_CONV: begin
				if (conv_done) begin
					state_next = i2d_pkg::ST_START;
				end
			end
			i2d_pkg::ST_START: begin
				state_next = i2d_pkg::ST_EMIT;
			end
			i2d_pkg::ST_EMIT: begin
				if (emit_done) begin
					state_next = i2d_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = i2d_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		shift_en = 1'b0;
		emit_start.start = 1'b0;
		unique case (state_q)
			i2d_pkg::ST_IDLE:  s_tready = 1'b1;
			i2d_pkg::ST_CONV:  shift_en = 1'b1;
			i2d_pkg::ST_START: emit_start.start = 1'b1;
			i2d_pkg::ST_EMIT:  s_tready = 1'b0;
			default:           s_tready = 1'b0;
		endcase
		emit_start.negative = neg_q;
		emit_start.top_idx  = num_digits - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= i2d_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= value_high[i2d_pkg::HalfW-1];
		end
	end

	i2d_dabble u_dabble (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (accept),
		.magnitude  (magnitude),
		.shift_en   (shift_en),
		.done       (conv_done),
		.digits     (digits),
		.num_digits (num_digits)
	);

	i2d_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (emit_start),
		.digits   (digits),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.done     (emit_done)
	);

endmodule
